// File: design/noise_channel_lfsr_envelope_unit_defines.svh
// Assertion macros for the noise channel unit.
// Taken in by every module that carries concurrent assertions; no other dependencies.
`ifndef NOISE_CHANNEL_LFSR_ENVELOPE_UNIT_DEFINES_SVH
`define NOISE_CHANNEL_LFSR_ENVELOPE_UNIT_DEFINES_SVH

`ifndef SYNTH
// Check on every rising edge outside reset
`define NCLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every rising edge, reset included
`define NCLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NCLE_ASSERT(lbl, prop, msg)
`define NCLE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: design/ncle_pkg.sv
// Shared types, codes, constants and lookup tables of the noise channel unit.
// No dependencies; used by the controller, the datapath and the top level.
package ncle_pkg;

    // Item kinds
    localparam logic [2:0] KIND_WRITE    = 3'd0;
    localparam logic [2:0] KIND_READ     = 3'd1;
    localparam logic [2:0] KIND_ADVANCE  = 3'd2;
    localparam logic [2:0] KIND_LENGTH   = 3'd3;
    localparam logic [2:0] KIND_ENVELOPE = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_NR40 = 3'd0;
    localparam logic [2:0] REG_NR41 = 3'd1;
    localparam logic [2:0] REG_NR42 = 3'd2;
    localparam logic [2:0] REG_NR43 = 3'd3;
    localparam logic [2:0] REG_NR44 = 3'd4;

    // Widths
    localparam int PERIOD_W = 23;
    localparam int FREQ_W   = 20;
    localparam int BASE_W   = 21;
    localparam int STEP_W   = 5;

    // Reset values and fixed constants
    localparam logic [7:0]  LENGTH_RESET  = 8'hFF;
    localparam logic [7:0]  CONTROL_RESET = 8'hBF;
    localparam logic [7:0]  READ_ONES     = 8'hBF;
    localparam logic [7:0]  READ_ALL_ONES = 8'hFF;
    localparam logic [14:0] LFSR_SEED     = 15'h7FFF;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 23'd8;
    localparam logic [6:0]  LEN_FULL      = 7'd64;
    localparam logic [3:0]  VOL_MAX       = 4'd15;

    // Divider runs one quotient bit per step, top bit first; numerator is 2^22
    localparam logic [STEP_W-1:0] DIV_TOP = 5'd22;
    // Modulo quotient never exceeds 32, so six shifted subtracts suffice
    localparam logic [STEP_W-1:0] MOD_TOP = 5'd5;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              capture;
        logic              exec;
        logic              div_init;
        logic              div_step;
        logic              div_load;
        logic              mod_step;
        logic              mod_store;
        logic              emit;
        logic [STEP_W-1:0] step;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_div;
        logic need_mod;
    } stat_t;

    // Base frequency before the shift: 2^20 for a zero divisor code, else 2^19 / r
    function automatic logic [BASE_W-1:0] base_freq(input logic [2:0] r);
        logic [BASE_W-1:0] f;
        unique case (r)
            3'd0: f = 21'd1048576;
            3'd1: f = 21'd524288;
            3'd2: f = 21'd262144;
            3'd3: f = 21'd174762;
            3'd4: f = 21'd131072;
            3'd5: f = 21'd104857;
            3'd6: f = 21'd87381;
            3'd7: f = 21'd74898;
            default: f = 21'd1048576;
        endcase
        return f;
    endfunction

    // Positive sample magnitude: trunc(32767 * v / 15)
    function automatic logic [15:0] pos_mag(input logic [3:0] v);
        logic [15:0] m;
        unique case (v)
            4'd0:  m = 16'd0;
            4'd1:  m = 16'd2184;
            4'd2:  m = 16'd4368;
            4'd3:  m = 16'd6553;
            4'd4:  m = 16'd8737;
            4'd5:  m = 16'd10922;
            4'd6:  m = 16'd13106;
            4'd7:  m = 16'd15291;
            4'd8:  m = 16'd17475;
            4'd9:  m = 16'd19660;
            4'd10: m = 16'd21844;
            4'd11: m = 16'd24029;
            4'd12: m = 16'd26213;
            4'd13: m = 16'd28398;
            4'd14: m = 16'd30582;
            4'd15: m = 16'd32767;
            default: m = 16'd0;
        endcase
        return m;
    endfunction

    // Negative sample magnitude: trunc(32768 * v / 15)
    function automatic logic [15:0] neg_mag(input logic [3:0] v);
        logic [15:0] m;
        unique case (v)
            4'd0:  m = 16'd0;
            4'd1:  m = 16'd2184;
            4'd2:  m = 16'd4369;
            4'd3:  m = 16'd6553;
            4'd4:  m = 16'd8738;
            4'd5:  m = 16'd10922;
            4'd6:  m = 16'd13107;
            4'd7:  m = 16'd15291;
            4'd8:  m = 16'd17476;
            4'd9:  m = 16'd19660;
            4'd10: m = 16'd21845;
            4'd11: m = 16'd24029;
            4'd12: m = 16'd26214;
            4'd13: m = 16'd28398;
            4'd14: m = 16'd30583;
            4'd15: m = 16'd32768;
            default: m = 16'd0;
        endcase
        return m;
    endfunction

endpackage

// File: design/ncle_ctrl.sv
// Sequencer of the noise channel unit: item acceptance, divide and modulo
// step counting, result register valid. Depends on ncle_pkg and the defines header.
`include "noise_channel_lfsr_envelope_unit_defines.svh"

module ncle_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    output logic            result_valid,
    input  logic            result_stall,
    input  ncle_pkg::stat_t stat,
    output ncle_pkg::cmd_t  cmd
);
    import ncle_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_EXEC     = 3'd1;
    localparam logic [2:0] ST_DIV_INIT = 3'd2;
    localparam logic [2:0] ST_DIV_STEP = 3'd3;
    localparam logic [2:0] ST_DIV_LOAD = 3'd4;
    localparam logic [2:0] ST_MOD_STEP = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              result_valid_reg, result_valid_next;
    logic              emit_ok;

    // Sequence one word through execute, optional divide or modulo, then emit
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        emit_ok    = !result_valid_reg || !result_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.need_div)
                begin
                    state_next = ST_DIV_INIT;
                end
                else if (stat.need_mod)
                begin
                    step_next  = MOD_TOP;
                    state_next = ST_MOD_STEP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = DIV_TOP;
                state_next   = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_DIV_LOAD;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DONE;
            end
            ST_MOD_STEP:
            begin
                cmd.mod_step = 1'b1;
                if (step_reg == '0)
                begin
                    cmd.mod_store = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result valid until the word is taken
    assign result_valid_next = cmd.emit || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;

    `NCLE_ASSERT(a_accept_to_exec, item_valid && !item_stall |=> state_reg == ST_EXEC, "accepted word did not enter execute")
    `NCLE_ASSERT(a_div_step_range, state_reg == ST_DIV_STEP |-> step_reg <= DIV_TOP, "divide step counter out of range")
    `NCLE_ASSERT(a_done_holds, state_reg == ST_DONE && result_valid && result_stall |=> state_reg == ST_DONE, "result overwritten while stalled")
    `NCLE_ASSERT_ALWAYS(a_reset_no_valid, !rst_n |-> (result_valid !== 1'b1), "result valid during reset")

endmodule

// File: design/ncle_datapath.sv
// Datapath of the noise channel unit: registers, length and envelope counters,
// LFSR, period divider, cycle count modulo and result register. Depends on ncle_pkg.
`include "noise_channel_lfsr_envelope_unit_defines.svh"

module ncle_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ncle_pkg::cmd_t       cmd,
    output ncle_pkg::stat_t      stat,
    input  logic [2:0]           kind,
    input  logic [2:0]           reg_index,
    input  logic [7:0]           write_data,
    input  logic [7:0]           cycles,
    output logic [7:0]           read_data,
    output logic signed [15:0]   sample,
    output logic                 channel_on
);
    import ncle_pkg::*;

    // Length reload: 64 minus the low six bits
    function automatic logic [6:0] len_reload(input logic [7:0] b);
        return LEN_FULL - {1'b0, b[5:0]};
    endfunction

    // Latched word
    logic [2:0] kind_reg, idx_reg;
    logic [7:0] data_reg, cyc_reg;

    // Channel state
    logic [7:0]          length_reg, length_next;
    logic [7:0]          envelope_reg, envelope_next;
    logic [7:0]          poly_reg, poly_next;
    logic [7:0]          control_reg, control_next;
    logic                active_reg, active_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [PERIOD_W-1:0] count_reg, count_next;
    logic [6:0]          len_left_reg, len_left_next;
    logic                len_en_reg, len_en_next;
    logic [3:0]          volume_reg, volume_next;
    logic                env_up_reg, env_up_next;
    logic [2:0]          env_period_reg, env_period_next;
    logic [2:0]          env_left_reg, env_left_next;
    logic                env_run_reg, env_run_next;
    logic [14:0]         shift_reg, shift_next;
    logic                zombie_reg, zombie_next;

    // Work registers
    logic [7:0]          rd_reg, rd_next;
    logic [FREQ_W-1:0]   div_den_reg, div_den_next;
    logic [FREQ_W-1:0]   div_rem_reg, div_rem_next;
    logic [PERIOD_W-1:0] div_quo_reg, div_quo_next;
    logic [PERIOD_W-1:0] mod_rem_reg, mod_rem_next;

    // Combinational helpers
    logic [14:0]         lfsr_step;
    logic                fb;
    logic [PERIOD_W-1:0] adv_sum;
    logic [6:0]          len_dec;
    logic [2:0]          env_dec;
    logic [3:0]          vol_step;
    logic [BASE_W-1:0]   freq_shifted;
    logic [FREQ_W:0]     rem_shift;
    logic [27:0]         mod_cmp;
    logic [27:0]         mod_ext;
    logic [15:0]         sample_val;

    // Tell the sequencer which long operation this word needs
    assign stat.need_div = (kind_reg == KIND_WRITE)
                        && ((idx_reg == REG_NR43) || (idx_reg == REG_NR44 && data_reg[7]));
    assign stat.need_mod = (kind_reg == KIND_ADVANCE);

    // Next LFSR value, with the short-mode tap into bit 6
    always_comb
    begin
        fb        = shift_reg[0] ^ shift_reg[1];
        lfsr_step = {fb, shift_reg[14:1]};
        if (poly_reg[3])
        begin
            lfsr_step[6] = fb;
        end
    end

    assign adv_sum  = count_reg + PERIOD_W'(cyc_reg);
    assign len_dec  = len_left_reg - 7'd1;
    assign env_dec  = env_left_reg - 3'd1;
    assign vol_step = env_up_reg ? ((volume_reg != VOL_MAX) ? volume_reg + 4'd1 : volume_reg)
                                 : ((volume_reg != 4'd0) ? volume_reg - 4'd1 : volume_reg);
    assign freq_shifted = base_freq(poly_reg[2:0]) >> ({1'b0, poly_reg[7:4]} + 5'd1);
    assign rem_shift    = {div_rem_reg, (cmd.step == DIV_TOP)};
    assign mod_cmp      = {5'd0, period_reg} << cmd.step[2:0];
    assign mod_ext      = {5'd0, mod_rem_reg};

    // Current sample from state
    always_comb
    begin
        if (!active_reg)
        begin
            sample_val = 16'd0;
        end
        else if (!shift_reg[0])
        begin
            sample_val = pos_mag(volume_reg);
        end
        else
        begin
            sample_val = 16'd0 - neg_mag(volume_reg);
        end
    end

    // Execute word operations and the divide and modulo steps
    always_comb
    begin
        length_next     = length_reg;
        envelope_next   = envelope_reg;
        poly_next       = poly_reg;
        control_next    = control_reg;
        active_next     = active_reg;
        period_next     = period_reg;
        count_next      = count_reg;
        len_left_next   = len_left_reg;
        len_en_next     = len_en_reg;
        volume_next     = volume_reg;
        env_up_next     = env_up_reg;
        env_period_next = env_period_reg;
        env_left_next   = env_left_reg;
        env_run_next    = env_run_reg;
        shift_next      = shift_reg;
        zombie_next     = zombie_reg;
        rd_next         = rd_reg;
        div_den_next    = div_den_reg;
        div_rem_next    = div_rem_reg;
        div_quo_next    = div_quo_reg;
        mod_rem_next    = mod_rem_reg;

        if (cmd.exec)
        begin
            rd_next = 8'd0;
            unique case (kind_reg)
                KIND_WRITE:
                begin
                    unique case (idx_reg)
                        REG_NR41:
                        begin
                            length_next   = data_reg;
                            len_left_next = len_reload(data_reg);
                            len_en_next   = control_reg[6];
                        end
                        REG_NR42:
                        begin
                            envelope_next = data_reg;
                            if (zombie_reg && data_reg[7:4] == 4'd0)
                            begin
                                active_next = 1'b0;
                            end
                        end
                        REG_NR43:
                        begin
                            poly_next = data_reg;
                        end
                        REG_NR44:
                        begin
                            control_next  = data_reg;
                            len_left_next = len_reload(length_reg);
                            len_en_next   = data_reg[6];
                            if (data_reg[7])
                            begin
                                // Trigger: restart length, envelope and LFSR
                                active_next     = 1'b1;
                                volume_next     = envelope_reg[7:4];
                                env_up_next     = envelope_reg[3];
                                env_period_next = envelope_reg[2:0];
                                env_left_next   = envelope_reg[2:0];
                                env_run_next    = (envelope_reg[2:0] != 3'd0);
                                shift_next      = LFSR_SEED;
                                zombie_next     = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                KIND_READ:
                begin
                    unique case (idx_reg)
                        REG_NR40: rd_next = READ_ALL_ONES;
                        REG_NR41: rd_next = READ_ALL_ONES;
                        REG_NR42: rd_next = envelope_reg;
                        REG_NR43: rd_next = poly_reg;
                        REG_NR44: rd_next = control_reg | READ_ONES;
                        default:  rd_next = 8'd0;
                    endcase
                end
                KIND_ADVANCE:
                begin
                    if (adv_sum >= period_reg)
                    begin
                        shift_next = lfsr_step;
                    end
                    mod_rem_next = adv_sum;
                end
                KIND_LENGTH:
                begin
                    if (active_reg && len_en_reg)
                    begin
                        len_left_next = len_dec;
                        if (len_dec == 7'd0)
                        begin
                            active_next = 1'b0;
                        end
                    end
                end
                KIND_ENVELOPE:
                begin
                    if (env_run_reg)
                    begin
                        if (env_dec != 3'd0)
                        begin
                            env_left_next = env_dec;
                        end
                        else
                        begin
                            volume_next   = vol_step;
                            env_left_next = env_period_reg;
                            if ((env_up_reg && vol_step == VOL_MAX)
                                || (!env_up_reg && vol_step == 4'd0))
                            begin
                                env_run_next = 1'b0;
                                zombie_next  = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Load the divisor: shifted frequency, never below one
        if (cmd.div_init)
        begin
            div_den_next = (freq_shifted == '0) ? FREQ_W'(1) : FREQ_W'(freq_shifted);
            div_rem_next = '0;
            div_quo_next = '0;
        end

        // Restoring divide, one quotient bit per step
        if (cmd.div_step)
        begin
            if (rem_shift >= {1'b0, div_den_reg})
            begin
                div_rem_next = FREQ_W'(rem_shift - {1'b0, div_den_reg});
                div_quo_next = {div_quo_reg[PERIOD_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_next = rem_shift[FREQ_W-1:0];
                div_quo_next = {div_quo_reg[PERIOD_W-2:0], 1'b0};
            end
        end

        // Install the new period and clamp the count
        if (cmd.div_load)
        begin
            period_next = div_quo_reg;
            if (div_quo_reg < count_reg)
            begin
                count_next = div_quo_reg;
            end
        end

        // Modulo by shifted subtracts of the period
        if (cmd.mod_step)
        begin
            if (mod_ext >= mod_cmp)
            begin
                mod_rem_next = PERIOD_W'(mod_ext - mod_cmp);
            end
        end
        if (cmd.mod_store)
        begin
            count_next = mod_rem_next;
        end
    end

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            idx_reg  <= reg_index;
            data_reg <= write_data;
            cyc_reg  <= cycles;
        end
    end

    // Work and result registers
    always_ff @(posedge clk)
    begin
        rd_reg      <= rd_next;
        div_den_reg <= div_den_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        mod_rem_reg <= mod_rem_next;
        if (cmd.emit)
        begin
            read_data  <= rd_reg;
            sample     <= signed'(sample_val);
            channel_on <= active_reg;
        end
    end

    // Channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg     <= LENGTH_RESET;
            envelope_reg   <= 8'd0;
            poly_reg       <= 8'd0;
            control_reg    <= CONTROL_RESET;
            active_reg     <= 1'b0;
            period_reg     <= PERIOD_RESET;
            count_reg      <= '0;
            len_left_reg   <= 7'd0;
            len_en_reg     <= 1'b0;
            volume_reg     <= 4'd0;
            env_up_reg     <= 1'b0;
            env_period_reg <= 3'd0;
            env_left_reg   <= 3'd0;
            env_run_reg    <= 1'b0;
            shift_reg      <= LFSR_SEED;
            zombie_reg     <= 1'b0;
        end
        else
        begin
            length_reg     <= length_next;
            envelope_reg   <= envelope_next;
            poly_reg       <= poly_next;
            control_reg    <= control_next;
            active_reg     <= active_next;
            period_reg     <= period_next;
            count_reg      <= count_next;
            len_left_reg   <= len_left_next;
            len_en_reg     <= len_en_next;
            volume_reg     <= volume_next;
            env_up_reg     <= env_up_next;
            env_period_reg <= env_period_next;
            env_left_reg   <= env_left_next;
            env_run_reg    <= env_run_next;
            shift_reg      <= shift_next;
            zombie_reg     <= zombie_next;
        end
    end

    `NCLE_ASSERT(a_period_min, period_reg >= PERIOD_RESET, "noise period below minimum")
    `NCLE_ASSERT(a_count_bound, count_reg <= period_reg, "cycle count beyond period")
    `NCLE_ASSERT(a_length_bound, len_left_reg <= LEN_FULL, "length counter beyond full scale")

endmodule

// File: design/noise_channel_lfsr_envelope_unit.sv
// Top level of the noise channel unit: joins the sequencer and the datapath.
// Depends on ncle_pkg, ncle_ctrl and ncle_datapath.
//
// Usage: each input word (kind, reg_index, write_data, cycles) is a register
// write, a register read, a clock advance, a length clock or an envelope clock.
// A word is taken when item_valid is high and item_stall is low; every word
// returns one result word (read_data, sample, channel_on), taken when
// result_valid is high and result_stall is low.
// Work per word: reads, length and envelope clocks and most writes go through
// execute and emit only; an advance adds six shifted subtract steps of the cycle
// count modulo; an NR43 write or a trigger adds a 23-step restoring divide for
// the period. result_valid is registered from the emit, the last step.
// One word is in work at a time; the result register frees the sequencer, so
// a new word may be taken while the previous result still waits.
// While result_stall holds a pending result, the next word finishes its work
// and waits to emit; item_stall stays high until then.
// Reset gives sequencer and channel state power-on values; clears result_valid.
module noise_channel_lfsr_envelope_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [2:0]         kind,
    input  logic [2:0]         reg_index,
    input  logic [7:0]         write_data,
    input  logic [7:0]         cycles,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [7:0]         read_data,
    output logic signed [15:0] sample,
    output logic               channel_on
);
    import ncle_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer
    ncle_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Datapath
    ncle_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .kind       (kind),
        .reg_index  (reg_index),
        .write_data (write_data),
        .cycles     (cycles),
        .read_data  (read_data),
        .sample     (sample),
        .channel_on (channel_on)
    );

endmodule
